// File: rtl/leaf_gradient_statistics_rows_unit_defines.svh
// ----------------------------------------------------------------------------
// Leaf gradient statistics rows: assertion macros
// Shared concurrent assertion shorthands, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef LEAF_GRADIENT_STATISTICS_ROWS_UNIT_DEFINES_SVH
`define LEAF_GRADIENT_STATISTICS_ROWS_UNIT_DEFINES_SVH

// Same-cycle implication.
`define LGSR_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define LGSR_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: rtl/lgsr_pkg.sv
// ----------------------------------------------------------------------------
// lgsr_pkg
// Types, constants and helpers shared by the leaf gradient statistics rows unit.
// ----------------------------------------------------------------------------
package lgsr_pkg;

  localparam int unsigned VALUE_INPUTS     = 4;
  localparam int unsigned MAX_FEATURES_DEF = 4;
  localparam int unsigned FRAC_BITS        = 16;
  localparam int unsigned IN_W             = 32;
  localparam int unsigned STAT_W           = 64;
  localparam int unsigned POS_W            = 5;
  localparam int unsigned CFG_W            = 3;
  localparam int unsigned CFG_IDX_W        = 1;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_MODE      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FEATURE_COUNT = 1'b1;
  localparam logic [CFG_W-1:0]     FEATURE_COUNT_RST = 3'd1;

  typedef enum logic [1:0] {
    MODE_ROOT,
    MODE_FULL,
    MODE_AUGMENT,
    MODE_IDLE
  } mode_e;

  typedef logic signed [IN_W-1:0]   word_t;
  typedef logic signed [STAT_W-1:0] stat_t;

  typedef struct packed {
    word_t gradient;
    word_t hessian;
    word_t value_0;
    word_t value_1;
    word_t value_2;
    word_t value_3;
  } in_t;

  typedef struct packed {
    stat_t            stat_value;
    logic [POS_W-1:0] stat_position;
    logic             row_last;
  } out_t;

  // Stage load strobes of the lane pipeline.
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } pipe_ctrl_t;

  // Row position of the first term of feature j in a full row.
  function automatic int unsigned feat_base(int j);
    return 2 + 3 * j + ((j * (j - 1)) >> 1);
  endfunction

endpackage

// File: rtl/lgsr_lane.sv
// ----------------------------------------------------------------------------
// lgsr_lane
// Three-stage product lane for one feature: v*g, v*h, then v_k*(v*h) for all
// k up to this feature, each truncated to 16 fractional bits.
// ----------------------------------------------------------------------------
module lgsr_lane #(
  parameter int unsigned LANE  = 0,
  parameter int unsigned TERMS = 6
) (
  input  logic                clk_i,
  input  lgsr_pkg::pipe_ctrl_t ctrl_i,
  input  lgsr_pkg::word_t     grad_i,
  input  lgsr_pkg::word_t     hess_i,
  input  lgsr_pkg::word_t     val_i [LANE+1],
  output lgsr_pkg::stat_t     term_o [TERMS]
);
  import lgsr_pkg::*;

  localparam int unsigned NV   = LANE + 1;
  localparam int unsigned BH_W = 2 * IN_W - FRAC_BITS;
  localparam int unsigned LO_W = FRAC_BITS + 1;
  localparam int unsigned PL_W = IN_W + LO_W;

  stat_t                  vg_q;
  stat_t                  vh_q;
  word_t                  v1_q [NV];
  logic signed [BH_W-1:0] vg2_q;
  logic signed [BH_W-1:0] bh2_q;
  stat_t                  ph_q [NV];
  logic signed [PL_W-1:0] pl_q [NV];
  stat_t                  vg3_q;
  stat_t                  bh3_q;
  stat_t                  prod3_q [NV];

  logic signed [BH_W-1:0] bh;
  word_t                  bh_hi;
  logic signed [LO_W-1:0] bh_lo;

  // v*h split into high word and unsigned low fraction for the triple products
  assign bh    = BH_W'(vh_q >>> FRAC_BITS);
  assign bh_hi = bh[BH_W-1 -: IN_W];
  assign bh_lo = {1'b0, bh[FRAC_BITS-1:0]};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld1) begin
      vg_q <= val_i[LANE] * grad_i;
      vh_q <= val_i[LANE] * hess_i;
      for (int k = 0; k < NV; k++) begin
        v1_q[k] <= val_i[k];
      end
    end
    if (ctrl_i.ld2) begin
      vg2_q <= BH_W'(vg_q >>> FRAC_BITS);
      bh2_q <= bh;
      for (int k = 0; k < NV; k++) begin
        ph_q[k] <= v1_q[k] * bh_hi;
        pl_q[k] <= v1_q[k] * bh_lo;
      end
    end
    if (ctrl_i.ld3) begin
      vg3_q <= STAT_W'(vg2_q);
      bh3_q <= STAT_W'(bh2_q);
      for (int k = 0; k < NV; k++) begin
        prod3_q[k] <= ph_q[k] + STAT_W'(pl_q[k] >>> FRAC_BITS);
      end
    end
  end

  always_comb begin
    for (int t = 0; t < TERMS; t++) begin
      term_o[t] = '0;
    end
    term_o[0] = vg3_q;
    term_o[1] = bh3_q;
    term_o[2] = prod3_q[LANE];
    for (int k = 0; k < LANE; k++) begin
      term_o[3+k] = prod3_q[k];
    end
  end

endmodule

// File: rtl/lgsr_row.sv
// ----------------------------------------------------------------------------
// lgsr_row
// Merge stage: gathers lane terms into the row for the current mode and
// shifts it out one statistic per transfer.
// ----------------------------------------------------------------------------
`include "leaf_gradient_statistics_rows_unit_defines.svh"

module lgsr_row #(
  parameter int unsigned LANES = 4,
  parameter int unsigned TERMS = 6,
  parameter int unsigned LIDX_W = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  lgsr_pkg::word_t     grad_i,
  input  lgsr_pkg::word_t     hess_i,
  input  lgsr_pkg::stat_t     term_i [LANES][TERMS],
  input  lgsr_pkg::mode_e     mode_i,
  input  logic [LIDX_W-1:0]   last_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lgsr_pkg::out_t      out_data_o
);
  import lgsr_pkg::*;

  localparam int unsigned ROW_MAX = feat_base(LANES);

  stat_t            row_d [ROW_MAX];
  logic [POS_W-1:0] len_d;
  stat_t            row_q [ROW_MAX];
  logic             out_valid_q;
  logic [POS_W-1:0] pos_q;
  logic [POS_W-1:0] last_q;
  logic             is_last;
  logic             xfer;
  logic             load;

  always_comb begin
    for (int p = 0; p < ROW_MAX; p++) begin
      row_d[p] = '0;
    end
    len_d = '0;
    case (mode_i)
      MODE_ROOT: begin
        row_d[0] = STAT_W'(grad_i);
        row_d[1] = STAT_W'(hess_i);
        len_d    = POS_W'(2);
      end
      MODE_FULL: begin
        row_d[0] = STAT_W'(grad_i);
        row_d[1] = STAT_W'(hess_i);
        for (int j = 0; j < LANES; j++) begin
          for (int t = 0; t < j + 3; t++) begin
            row_d[feat_base(j)+t] = term_i[j][t];
          end
          if (j == int'(last_i)) begin
            len_d = POS_W'(feat_base(j + 1));
          end
        end
      end
      MODE_AUGMENT: begin
        for (int j = 0; j < LANES; j++) begin
          if (j == int'(last_i)) begin
            for (int t = 0; t < TERMS; t++) begin
              row_d[t] = term_i[j][t];
            end
            len_d = POS_W'(j + 3);
          end
        end
      end
      default: ;
    endcase
  end

  assign is_last = (pos_q == last_q);
  assign xfer    = out_valid_q && out_ready_i;
  assign ready_o = !out_valid_q || (out_ready_i && is_last);
  assign load    = valid_i && ready_o && (len_d != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      last_q      <= '0;
    end else if (load) begin
      out_valid_q <= 1'b1;
      pos_q       <= '0;
      last_q      <= len_d - POS_W'(1);
    end else if (xfer) begin
      if (is_last) begin
        out_valid_q <= 1'b0;
      end
      pos_q <= pos_q + POS_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      row_q <= row_d;
    end else if (xfer) begin
      for (int i = 0; i < ROW_MAX - 1; i++) begin
        row_q[i] <= row_q[i+1];
      end
    end
  end

  assign out_valid_o              = out_valid_q;
  assign out_data_o.stat_value    = row_q[0];
  assign out_data_o.stat_position = pos_q;
  assign out_data_o.row_last      = is_last;

  `LGSR_ASSERT_NEXT(a_row_continues, xfer && !is_last, out_valid_q, "row ended early")
  `LGSR_ASSERT_NEXT(a_pos_step, xfer && !is_last, pos_q == $past(pos_q) + POS_W'(1), "bad step")
  `LGSR_ASSERT_IMP(a_pos_bound, out_valid_q, pos_q <= last_q, "position past row end")
  `LGSR_ASSERT_IMP(a_len_bound, out_valid_q, last_q < POS_W'(ROW_MAX), "row length too large")
  `LGSR_ASSERT_NEXT(a_hold, out_valid_q && !out_ready_i, $stable(row_q[0]) && $stable(pos_q), "moved")

endmodule

// File: rtl/leaf_gradient_statistics_rows_unit.sv
// ----------------------------------------------------------------------------
// leaf_gradient_statistics_rows_unit
// A sample passes the lane pipeline stages and the row register before its first
// statistic is valid. Throughput: one statistic per cycle on the result channel
// while out_ready_i is high; a row has 2 to 20 statistics, idle-mode samples none.
// Reset: asynchronous, clears the pipeline and sets row_mode 0, feature_count 1.
// ----------------------------------------------------------------------------
module leaf_gradient_statistics_rows_unit #(
  parameter int unsigned MAX_FEATURES = lgsr_pkg::MAX_FEATURES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lgsr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lgsr_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  lgsr_pkg::in_t                     in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output lgsr_pkg::out_t                    out_data_o
);
  import lgsr_pkg::*;

  localparam int unsigned LANES  = (MAX_FEATURES < VALUE_INPUTS) ? MAX_FEATURES : VALUE_INPUTS;
  localparam int unsigned TERMS  = LANES + 2;
  localparam int unsigned LIDX_W = (LANES > 1) ? $clog2(LANES) : 1;

  mode_e             mode_q;
  logic [CFG_W-1:0]  fcnt_q;
  logic [LIDX_W-1:0] last_lane;

  logic       v1_q, v2_q, v3_q;
  logic       rdy1, rdy2, rdy3;
  logic       row_rdy;
  pipe_ctrl_t ctrl;
  word_t      g1_q, g2_q, g3_q;
  word_t      h1_q, h2_q, h3_q;
  word_t      in_vals [VALUE_INPUTS];
  stat_t      lane_terms [LANES][TERMS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_ROOT;
      fcnt_q <= FEATURE_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ROW_MODE:      mode_q <= mode_e'(cfg_wdata_i[1:0]);
        REG_FEATURE_COUNT: fcnt_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (fcnt_q == '0) begin
      last_lane = '0;
    end else if (fcnt_q > CFG_W'(LANES)) begin
      last_lane = LIDX_W'(LANES - 1);
    end else begin
      last_lane = LIDX_W'(fcnt_q - CFG_W'(1));
    end
  end

  assign rdy3       = !v3_q || row_rdy;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;
  assign ctrl.ld1   = in_valid_i && rdy1;
  assign ctrl.ld2   = v1_q && rdy2;
  assign ctrl.ld3   = v2_q && rdy3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.ld1) begin
      g1_q <= in_data_i.gradient;
      h1_q <= in_data_i.hessian;
    end
    if (ctrl.ld2) begin
      g2_q <= g1_q;
      h2_q <= h1_q;
    end
    if (ctrl.ld3) begin
      g3_q <= g2_q;
      h3_q <= h2_q;
    end
  end

  assign in_vals[0] = in_data_i.value_0;
  assign in_vals[1] = in_data_i.value_1;
  assign in_vals[2] = in_data_i.value_2;
  assign in_vals[3] = in_data_i.value_3;

  for (genvar j = 0; j < LANES; j++) begin : g_lane
    lgsr_lane #(
      .LANE  (j),
      .TERMS (TERMS)
    ) u_lane (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .grad_i (in_data_i.gradient),
      .hess_i (in_data_i.hessian),
      .val_i  (in_vals[0:j]),
      .term_o (lane_terms[j])
    );
  end

  lgsr_row #(
    .LANES  (LANES),
    .TERMS  (TERMS),
    .LIDX_W (LIDX_W)
  ) u_row (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (v3_q),
    .ready_o     (row_rdy),
    .grad_i      (g3_q),
    .hess_i      (h3_q),
    .term_i      (lane_terms),
    .mode_i      (mode_q),
    .last_i      (last_lane),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: verif/leaf_gradient_statistics_rows_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Leaf gradient statistics rows unit testbench
// Sends training samples in every row mode with fixed and random feature counts, including
// out-of-range counts and operand extremes. Each accepted sample is expanded
// into its expected statistics row, and every result transfer is checked
// field by field in order. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;
  import lgsr_pkg::*;

  localparam word_t W_MIN      = 32'sh8000_0000;
  localparam word_t W_MAX      = 32'sh7fff_ffff;
  localparam int    DRAIN_WAIT = 8;
  localparam int    STALL_MAX  = 1000;

  class row_stats_scoreboard;
    out_t        pending_stats[$];
    mode_e       mode_q  = MODE_ROOT;
    logic [2:0]  count_q = FEATURE_COUNT_RST;
    int          errors  = 0;

    function stat_t prod_q16(word_t a, word_t b);
      logic signed [63:0] p;
      p = a * b;
      return p >>> FRAC_BITS;
    endfunction

    function stat_t prod_wide(word_t a, stat_t w);
      logic signed [127:0] p;
      logic signed [127:0] q;
      p = a * w;
      q = p >>> FRAC_BITS;
      return q[63:0];
    endfunction

    function void note_sample(in_t s);
      word_t v[4];
      stat_t row[$];
      stat_t bh;
      int    nf;
      int    limit;
      int    first;
      out_t  item;
      v = '{s.value_0, s.value_1, s.value_2, s.value_3};
      limit = (MAX_FEATURES_DEF < VALUE_INPUTS) ? MAX_FEATURES_DEF : VALUE_INPUTS;
      nf = int'(count_q);
      if (nf < 1) nf = 1;
      if (nf > limit) nf = limit;
      if (mode_q == MODE_IDLE) return;
      if (mode_q != MODE_AUGMENT) begin
        row = {row, stat_t'(s.gradient)};
        row = {row, stat_t'(s.hessian)};
      end
      if (mode_q != MODE_ROOT) begin
        first = (mode_q == MODE_FULL) ? 0 : nf - 1;
        for (int j = first; j < nf; j++) begin
          bh = prod_q16(v[j], s.hessian);
          row = {row, prod_q16(v[j], s.gradient)};
          row = {row, bh};
          row = {row, prod_wide(v[j], bh)};
          for (int k = 0; k < j; k++) row = {row, prod_wide(v[k], bh)};
        end
      end
      foreach (row[i]) begin
        item.stat_value    = row[i];
        item.stat_position = POS_W'(i);
        item.row_last      = (i == row.size() - 1);
        pending_stats = {pending_stats, item};
      end
    endfunction

    function void check_stat(out_t got);
      out_t want;
      if (pending_stats.size() == 0) begin
        $error("unexpected statistic: value %0d position %0d last %0b",
               got.stat_value, got.stat_position, got.row_last);
        errors++;
        return;
      end
      want = pending_stats.pop_front();
      if (got.stat_value !== want.stat_value) begin
        $error("stat_value: expected %0d, got %0d", want.stat_value, got.stat_value);
        errors++;
      end
      if (got.stat_position !== want.stat_position) begin
        $error("stat_position: expected %0d, got %0d",
               want.stat_position, got.stat_position);
        errors++;
      end
      if (got.row_last !== want.row_last) begin
        $error("row_last: expected %0b, got %0b", want.row_last, got.row_last);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = REG_ROW_MODE;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  in_t                  in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_t                 out_data_o;

  row_stats_scoreboard sb = new();
  bit                  steady = 1'b0;
  int                  stall_cycles = 0;

  leaf_gradient_statistics_rows_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(0, 99) >= 26);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_stat(out_data_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_MAX) begin
        $display("** leaf_gradient_statistics_rows_unit: FAILED **");
        $finish;
      end
    end
  end

  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      0:       return W_MIN;
      1:       return W_MAX;
      2:       return '0;
      3:       return -32'sd1;
      4, 5:    return word_t'($urandom_range(0, 1 << 20)) - word_t'(1 << 19);
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic in_t uniform(word_t x);
    return in_t'{x, x, x, x, x, x};
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_sample(input in_t s);
    while (!steady && $urandom_range(0, 99) < 26) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= s;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(s);
    @(negedge clk_i);
  endtask

  task automatic drain_rows();
    in_valid_i <= 1'b0;
    while (sb.pending_stats.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  task automatic configure(input mode_e m, input logic [2:0] cnt);
    drain_rows();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_ROW_MODE;
    cfg_wdata_i <= {1'b0, m};
    @(negedge clk_i);
    cfg_idx_i   <= REG_FEATURE_COUNT;
    cfg_wdata_i <= cnt;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.mode_q  = m;
    sb.count_q = cnt;
  endtask

  initial begin
    mode_e m;
    int    n;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset configuration: root copy
    send_sample(in_t'{W_MAX, W_MIN, 32'sd1, 32'sd2, 32'sd3, 32'sd4});
    send_sample(in_t'{W_MIN, W_MAX, W_MAX, W_MIN, W_MAX, W_MIN});

    configure(MODE_FULL, 3'd4);
    send_sample(uniform(W_MAX));
    send_sample(uniform(W_MIN));
    send_sample(in_t'{W_MAX, W_MIN, W_MIN, W_MAX, W_MIN, W_MAX});
    send_sample(uniform('0));
    send_sample(uniform(-32'sd1));
    send_sample(uniform(32'sd1));
    send_sample(uniform(32'sh0001_0000));

    configure(MODE_FULL, 3'd0);
    send_sample(in_t'{32'sh0002_8000, -32'sh0001_4000, W_MIN, W_MAX, W_MAX, W_MAX});
    configure(MODE_FULL, 3'd7);
    send_sample(in_t'{W_MIN, W_MAX, -32'sd3, W_MAX, W_MIN, 32'sh0000_8000});

    configure(MODE_AUGMENT, 3'd4);
    send_sample(uniform(W_MAX));
    send_sample(uniform(W_MIN));
    configure(MODE_AUGMENT, 3'd1);
    send_sample(in_t'{W_MAX, W_MAX, W_MIN, W_MAX, W_MAX, W_MAX});
    configure(MODE_AUGMENT, 3'd5);
    send_sample(in_t'{-32'sd1, W_MIN, W_MIN, W_MAX, W_MIN, W_MIN});

    configure(MODE_IDLE, 3'd3);
    send_sample(uniform(W_MAX));
    send_sample(uniform(W_MIN));
    configure(MODE_ROOT, 3'd2);
    send_sample(uniform(-32'sd1));

    for (int phase = 0; phase < 12; phase++) begin
      case ($urandom_range(0, 9))
        0:          m = MODE_ROOT;
        1:          m = MODE_IDLE;
        2, 3, 4, 5: m = MODE_AUGMENT;
        default:    m = MODE_FULL;
      endcase
      configure(m, 3'($urandom_range(0, 7)));
      steady = (phase == 3);
      n = (m == MODE_IDLE) ? 6 : 36;
      for (int i = 0; i < n; i++) begin
        if (phase == 6 && i == n / 2) drain_rows();
        send_sample(in_t'{rand_word(), rand_word(), rand_word(),
                          rand_word(), rand_word(), rand_word()});
      end
    end
    steady = 1'b0;

    drain_rows();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_stats.size() == 0) begin
      $display("** leaf_gradient_statistics_rows_unit: PASSED **");
    end else begin
      $display("** leaf_gradient_statistics_rows_unit: FAILED **");
    end
    $finish;
  end

endmodule
